// ===== sv/windowed_fractional_rank_top_defines.svh =====
// assertion macros shared by the rank block
`ifndef WINDOWED_FRACTIONAL_RANK_TOP_DEFINES_SVH
`define WINDOWED_FRACTIONAL_RANK_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define WFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define WFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wfr_pkg.sv =====
`default_nettype none

package wfr_pkg;

  // field widths
  localparam int SAMPLE_W = 32;
  localparam int IDX_W    = 10;
  localparam int WL_W     = 11;
  localparam int RANK_W   = 12;

  // window defaults
  localparam int            WINDOW_DEFAULT = 1024;
  localparam logic [WL_W-1:0] WL_RESET     = 11'd1024;

  // compare chain: one cell per byte slice, most significant first
  localparam int SLICE_W   = 8;
  localparam int NUM_CELLS = SAMPLE_W / SLICE_W;
  localparam int DRAIN_W   = $clog2(NUM_CELLS + 1);
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(NUM_CELLS);

  // action codes
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_RANK  = 1'b1;

  typedef struct packed {
    logic                action;
    logic [IDX_W-1:0]    index;
    logic [SAMPLE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank_doubled;
    logic [IDX_W-1:0]  ranked_index;
  } result_t;

  // word moving down the compare chain
  typedef struct packed {
    logic                valid;
    logic                skip;
    logic                lt;
    logic                eq;
    logic [SAMPLE_W-1:0] sample;
  } cmp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OWN,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== sv/wfr_ram.sv =====
`default_nettype none

module wfr_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/wfr_cell.sv =====
`default_nettype none

module wfr_cell import wfr_pkg::*; #(
  parameter int SLICE = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SAMPLE_W-1:0] own,
  input  cmp_t                up,
  output cmp_t                down
);

  localparam int LO = (NUM_CELLS - 1 - SLICE) * SLICE_W;

  logic [SLICE_W-1:0] samp_sl;
  logic [SLICE_W-1:0] own_sl;
  cmp_t               down_next;

  // refine the ordering with this byte slice
  always_comb begin
    samp_sl             = up.sample[LO +: SLICE_W];
    own_sl              = own[LO +: SLICE_W];
    down_next           = up;
    down_next.lt        = up.lt | (up.eq & (samp_sl < own_sl));
    down_next.eq        = up.eq & (samp_sl == own_sl);
  end

  // hand the word to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else begin
      down.valid <= down_next.valid;
    end
    down.skip   <= down_next.skip;
    down.lt     <= down_next.lt;
    down.eq     <= down_next.eq;
    down.sample <= down_next.sample;
  end

endmodule

`default_nettype wire

// ===== sv/windowed_fractional_rank_top.sv =====
// Windowed fractional rank. A store word (action 0) writes value into the
// window RAM at index; busy stays low, so the next word can follow at once.
// A rank word (action 1) reads the named entry, then streams the first
// window_length entries (capped at WINDOW) out of the single read port of
// the window RAM, one entry per cycle, through a chain of byte-slice compare
// cells, and counts the smaller and equal ones. Busy stays high until the
// rank is done, so no new word is taken meanwhile; the result appears on
// result with done high for exactly one cycle, and the receiver cannot
// stall it. Ranking an entry that was never stored gives an undefined rank.
// Write cfg_data only while busy is low.
`default_nettype none
`include "windowed_fractional_rank_top_defines.svh"

module windowed_fractional_rank_top import wfr_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  in_word_t        in_word,
  output logic            busy,
  output logic            done,
  output result_t         result,
  input  logic            cfg_we,
  input  logic [WL_W-1:0] cfg_data
);

  localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int SUM_W = CW + 2;
  localparam logic [26:0] WIN27 = 27'(WINDOW);

  state_t              state;
  state_t              state_next;
  logic [WL_W-1:0]     window_length;
  logic [CW-1:0]       len_eff;
  logic [CW-1:0]       cnt;
  logic [DRAIN_W-1:0]  dcnt;
  logic [AW-1:0]       pos;
  logic [AW-1:0]       pos_q;
  logic [IDX_W-1:0]    idx_q;
  logic [SAMPLE_W-1:0] own;
  logic                tag_valid;
  logic                tag_skip;
  logic [CW-1:0]       smaller;
  logic [CW-1:0]       equal;
  logic [SUM_W-1:0]    doubled;
  logic                accept;
  logic                rank_take;
  logic                in_sweep;
  logic                issue;
  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [26:0]         wrap;
  cmp_t                chain [NUM_CELLS+1];

  // index modulo window by shifted-divisor subtraction
  always_comb begin
    wrap = 27'(in_word.index);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (wrap >= (WIN27 << k)) begin
        wrap = wrap - (WIN27 << k);
      end
    end
    pos = wrap[AW-1:0];
  end

  // effective window length, capped at the store depth
  always_comb begin
    if (32'(window_length) > WINDOW) begin
      len_eff = CW'(WINDOW);
    end else begin
      len_eff = CW'(window_length);
    end
  end

  assign accept    = start && !busy;
  assign ram_we    = accept && (in_word.action == ACT_STORE);
  assign rank_take = accept && (in_word.action == ACT_RANK);
  assign in_sweep  = (state == S_SWEEP) || (state == S_DRAIN);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (in_word.action == ACT_RANK)) begin
          state_next = S_OWN;
        end
      end
      S_OWN:   state_next = S_SWEEP;
      S_SWEEP: begin
        if (cnt >= len_eff) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (dcnt == DRAIN_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy      = 1'b1;
    done      = 1'b0;
    issue     = 1'b0;
    ram_raddr = pos;
    case (state)
      S_IDLE:  busy = 1'b0;
      S_OWN:   ram_raddr = pos_q;
      S_SWEEP: begin
        issue     = (cnt < len_eff);
        ram_raddr = cnt[AW-1:0];
      end
      S_DRAIN: ram_raddr = pos_q;
      S_DONE:  done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= WL_RESET;
      tag_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      tag_valid <= issue;
      if (cfg_we) begin
        window_length <= cfg_data;
      end
    end
  end

  // sweep counters and held query
  always_ff @(posedge clk) begin
    tag_skip <= (cnt[AW-1:0] == pos_q);
    if (accept) begin
      pos_q <= pos;
      idx_q <= in_word.index;
    end
    case (state)
      S_OWN: begin
        own <= ram_rdata;
        cnt <= '0;
      end
      S_SWEEP: begin
        dcnt <= '0;
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
      end
      S_DRAIN: dcnt <= dcnt + 1'b1;
      default: dcnt <= dcnt;
    endcase
  end

  wfr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (in_word.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // head of the compare chain: undecided, all equal so far
  assign chain[0] = '{valid: tag_valid, skip: tag_skip, lt: 1'b0, eq: 1'b1,
                      sample: ram_rdata};

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    wfr_cell #(
      .SLICE (g)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .own  (own),
      .up   (chain[g]),
      .down (chain[g+1])
    );
  end

  // tally decided words at the tail
  always_ff @(posedge clk) begin
    if (state == S_OWN) begin
      smaller <= '0;
      equal   <= '0;
    end else if (chain[NUM_CELLS].valid && !chain[NUM_CELLS].skip) begin
      if (chain[NUM_CELLS].lt) begin
        smaller <= smaller + 1'b1;
      end else if (chain[NUM_CELLS].eq) begin
        equal <= equal + 1'b1;
      end
    end
  end

  // doubled rank: 2 * (1 + smaller) + equal
  assign doubled = (SUM_W'(smaller) << 1) + SUM_W'(2) + SUM_W'(equal);
  assign result.rank_doubled = RANK_W'(doubled);
  assign result.ranked_index = idx_q;

  `WFR_ASSERT_NEXT(a_done_releases, done, !busy && !done, "busy held after result")
  `WFR_ASSERT_NEXT(a_rank_goes_busy, rank_take, busy, "rank word not taken")
  `WFR_ASSERT_NEXT(a_store_stays_idle, ram_we, !busy && !done, "store word started a rank")
  `WFR_ASSERT_NOW(a_tail_in_sweep, chain[NUM_CELLS].valid, in_sweep, "tail word outside sweep")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import wfr_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = WINDOW_DEFAULT + 16;
  localparam int WATCHDOG_LIMIT = 8 * (WINDOW_DEFAULT + 16);

  // one queued word for the driver: a command word or a window length write
  typedef struct packed {
    logic            is_setting;
    in_word_t        word;
    logic [WL_W-1:0] win_len;
    logic [6:0]      gap_pct;
  } pending_t;

  logic            clk      = 1'b0;
  logic            rst      = 1'b1;
  logic            start    = 1'b0;
  in_word_t        in_word  = '0;
  logic            busy;
  logic            done;
  result_t         result;
  logic            cfg_we   = 1'b0;
  logic [WL_W-1:0] cfg_data = '0;

  pending_t        pending_words[$];
  result_t         expected_ranks[$];

  // shadow of the block used to work out ranks
  logic [SAMPLE_W-1:0] window_model [0:WINDOW_DEFAULT-1];
  logic [WL_W-1:0]     win_len_model = WL_RESET;

  // generator side: which entries have been written so far
  bit          stored_mask [0:WINDOW_DEFAULT-1];
  logic [SAMPLE_W-1:0] sample_pool [0:5];
  int unsigned gap_pct = 38;

  bit          taken        = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_cycles  = 0;
  int unsigned fail_count   = 0;
  int unsigned stores_done  = 0;
  int unsigned ranks_done   = 0;
  int unsigned settings_done = 0;

  windowed_fractional_rank_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .in_word  (in_word),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // doubled fractional rank of the entry at idx within the current window
  function automatic logic [RANK_W-1:0] rank_of(input logic [IDX_W-1:0] idx);
    int unsigned span;
    int unsigned smaller;
    int unsigned equal;
    logic [SAMPLE_W-1:0] own;
    span    = (win_len_model > WINDOW_DEFAULT) ? WINDOW_DEFAULT : win_len_model;
    smaller = 0;
    equal   = 0;
    own     = window_model[idx];
    for (int unsigned t = 0; t < span; t++) begin
      if (t != idx) begin
        if (window_model[t] < own) smaller++;
        else if (window_model[t] == own) equal++;
      end
    end
    return RANK_W'(2 * (1 + smaller) + equal);
  endfunction

  // mostly values that repeat, so ties show up even in wide windows
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return sample_pool[$urandom_range(0, 5)];
      default: return $urandom;
    endcase
  endfunction

  task automatic report_fault(input string what);
    if (fail_count < 10) $display("error: %s", what);
    fail_count++;
  endtask

  task automatic push_store(input int unsigned idx, input logic [SAMPLE_W-1:0] val);
    pending_t p;
    p               = '0;
    p.word.action   = ACT_STORE;
    p.word.index    = IDX_W'(idx);
    p.word.value    = val;
    p.gap_pct       = 7'(gap_pct);
    stored_mask[idx % WINDOW_DEFAULT] = 1'b1;
    pending_words = {pending_words, p};
  endtask

  task automatic push_rank(input int unsigned idx);
    pending_t p;
    p               = '0;
    p.word.action   = ACT_RANK;
    p.word.index    = IDX_W'(idx);
    p.word.value    = $urandom;
    p.gap_pct       = 7'(gap_pct);
    pending_words = {pending_words, p};
  endtask

  task automatic push_setting(input int unsigned len);
    pending_t p;
    p            = '0;
    p.is_setting = 1'b1;
    p.win_len    = WL_W'(len);
    pending_words = {pending_words, p};
  endtask

  // one window setting: fill the unwritten part of the window, then mix
  // random stores and ranks of written entries
  task automatic add_phase(input int unsigned len, input int unsigned count);
    int unsigned span;
    int unsigned idx;
    span = (len > WINDOW_DEFAULT) ? WINDOW_DEFAULT : len;
    push_setting(len);
    for (int unsigned k = 0; k < span; k++) begin
      if (!stored_mask[k]) push_store(k, pick_sample());
    end
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 55) begin
        if (span != 0 && $urandom_range(0, 99) < 80) begin
          idx = $urandom_range(0, span - 1);
        end else begin
          idx = $urandom_range(0, WINDOW_DEFAULT - 1);
          while (!stored_mask[idx]) idx = $urandom_range(0, WINDOW_DEFAULT - 1);
        end
        push_rank(idx);
      end else begin
        if (span != 0 && $urandom_range(0, 99) < 70) idx = $urandom_range(0, span - 1);
        else idx = $urandom_range(0, WINDOW_DEFAULT - 1);
        push_store(idx, pick_sample());
      end
    end
  endtask

  // driver: present the next word, or write the window length once idle
  always @(negedge clk) begin : drive_words
    logic            nxt_start;
    logic            nxt_we;
    in_word_t        nxt_word;
    logic [WL_W-1:0] nxt_len;
    nxt_start = start;
    nxt_word  = in_word;
    nxt_we    = 1'b0;
    nxt_len   = cfg_data;
    if (!rst && !(start && !taken)) begin
      nxt_start = 1'b0;
      if (pending_words.size() != 0) begin
        if (pending_words[0].is_setting) begin
          if (expected_ranks.size() == 0 && !busy) quiet_cycles++;
          else quiet_cycles = 0;
          if (quiet_cycles > SETTLE_CYCLES) begin
            nxt_we  = 1'b1;
            nxt_len = pending_words[0].win_len;
            void'(pending_words.pop_front());
            quiet_cycles = 0;
          end
        end else if ($urandom_range(0, 99) >= pending_words[0].gap_pct) begin
          nxt_start = 1'b1;
          nxt_word  = pending_words[0].word;
          void'(pending_words.pop_front());
        end
      end
    end
    start    <= nxt_start;
    in_word  <= nxt_word;
    cfg_we   <= nxt_we;
    cfg_data <= nxt_len;
  end

  // monitor: check results, then fold accepted words into the shadow
  always @(posedge clk) begin : watch_results
    result_t want;
    taken <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        if (expected_ranks.size() == 0) begin
          report_fault($sformatf("unexpected result rank %0d index %0d",
                                 result.rank_doubled, result.ranked_index));
        end else begin
          want = expected_ranks.pop_front();
          ranks_done++;
          if (result.rank_doubled !== want.rank_doubled ||
              result.ranked_index !== want.ranked_index) begin
            report_fault($sformatf("expected rank %0d index %0d, got rank %0d index %0d",
                                   want.rank_doubled, want.ranked_index,
                                   result.rank_doubled, result.ranked_index));
          end
        end
      end
      if (cfg_we) begin
        win_len_model = cfg_data;
        settings_done++;
      end
      if (start && !busy) begin
        if (in_word.action == ACT_STORE) begin
          window_model[in_word.index] = in_word.value;
          stores_done++;
        end else begin
          want.rank_doubled = rank_of(in_word.index);
          want.ranked_index = in_word.index;
          expected_ranks = {expected_ranks, want};
        end
      end
    end
  end

  // watchdog on cycles with no word, result or setting moving
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < WINDOW_DEFAULT; k++) begin
      window_model[k] = '0;
      stored_mask[k]  = 1'b0;
    end
    for (int k = 0; k < 6; k++) sample_pool[k] = $urandom;

    // directed: value and index extremes, ties, short and empty windows,
    // ranked entry outside the window
    gap_pct = 38;
    push_setting(2);
    push_store(0, 32'h0000_0000);
    push_store(1, 32'hFFFF_FFFF);
    push_rank(0);
    push_rank(1);
    push_store(1, 32'h0000_0000);
    push_rank(1);
    push_store(1023, 32'h8000_0000);
    push_rank(1023);
    push_store(512, 32'h7FFF_FFFF);
    push_store(1023, 32'h0000_0000);
    push_rank(1023);
    push_rank(512);
    push_setting(1);
    push_rank(0);
    push_rank(1);
    push_setting(0);
    push_rank(0);
    push_rank(1023);

    // random: sender gaps at 38 percent, then 46, then none
    add_phase(2, 50);
    add_phase($urandom_range(3, 24), 60);
    add_phase($urandom_range(25, 64), 50);
    gap_pct = 46;
    add_phase($urandom_range(65, 200), 60);
    add_phase(1, 20);
    add_phase(0, 20);
    gap_pct = 0;
    add_phase($urandom_range(3, 16), 120);
    add_phase(2, 60);

    // reset
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drain
    while (pending_words.size() != 0 || start) @(posedge clk);
    while (expected_ranks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d stores and %0d checked ranks over %0d window length writes",
             stores_done, ranks_done, settings_done);
    $display("faults seen: %0d", fail_count);
    if (fail_count == 0 && expected_ranks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
